// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the sorter RTL.
// Expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define QKS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("qks assertion failed");

// Concurrent check that also holds during reset.
`define QKS_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("qks assertion failed");

`endif

// ===== rtl/core/qks_pkg.sv =====
// Shared constants, types and the key ordering function of the sorter.
// No dependencies.
`default_nettype none
package qks_pkg;
   localparam int MaxItemsDefault     = 1024;
   localparam int StackDepthDefault   = 11;
   localparam int PayloadWidthDefault = 32;

   localparam int KeyW      = 32;
   localparam int BusW      = 32;
   localparam int IdxFieldW = 10;
   localparam int ReqDataW  = 80;
   localparam int RspDataW  = 64;

   localparam logic CmdLoad = 1'b0;
   localparam logic CmdRead = 1'b1;

   localparam logic CsrFirstIndex = 1'b0;
   localparam logic CsrLastIndex  = 1'b1;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   // Monotone unsigned image of a float key; -0 maps like +0.
   function automatic logic [KeyW-1:0] order_of(input logic [KeyW-1:0] bits);
      logic [KeyW-1:0] b;
      b = (bits == 32'h8000_0000) ? '0 : bits;
      return b[KeyW-1] ? ~b : (b | 32'h8000_0000);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/quickersort_key_payload.sv =====
// Channel | dir | handshake           | contents
// req     | in  | req_tvalid/tready   | load or read request, last mark on tlast
// rsp     | out | rsp_tvalid/tready   | element read back, beyond-fill flag on tuser
// csr     | in  | csr_valid/ready     | first_index (0), last_index (1)
// Reads pass the store and result registers; one request in flight at a time.
// A last load starts the sort if first_index <= last_index and fill-1; the
// sequencer does at most one memory access per cycle, and req_tready stays low.
// Synchronous active-high reset clears fill count, set state and sequencer.
// rsp stalls hold the result register and block new requests.
// Depends on qks_pkg, qks_store, qks_sorter, assert_macros.svh.
`default_nettype none
module quickersort_key_payload #(
   parameter int MAX_ITEMS     = qks_pkg::MaxItemsDefault,
   parameter int STACK_DEPTH   = qks_pkg::StackDepthDefault,
   parameter int PAYLOAD_WIDTH = qks_pkg::PayloadWidthDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // key_bits[31:0], payload[63:32], read_index[73:64], zero[79:74]
   input  wire logic [qks_pkg::ReqDataW-1:0]    req_tdata,
   // command
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // key_out[31:0], payload_out[63:32]
   output logic [qks_pkg::RspDataW-1:0]         rsp_tdata,
   // beyond_fill
   output logic                                 rsp_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic                            csr_index,
   input  wire logic [qks_pkg::IdxFieldW-1:0]   csr_data
);
   import qks_pkg::*;

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int EW = KeyW + PAYLOAD_WIDTH;

   logic [IdxFieldW-1:0] first_ff, last_ff;
   logic [IW:0] fill_ff, fill_in;
   logic closed_ff, closed_in;
   logic rd_pend_ff, beyond_ff;
   logic rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;
   logic rsp_user_ff;

   logic req_ok, is_load, is_read;
   logic [IW:0] base;
   logic load_we;
   logic [63:0] pay_ext;
   logic [31:0] idx_w, fill_w, first_w, last_w, hi_w;
   logic start;
   logic sort_busy;
   mem_ctl_type s_ctl;
   logic [IW-1:0] s_raddr, s_waddr;
   logic [EW-1:0] s_wdata, rd_data;
   logic m_we, m_re;
   logic [IW-1:0] m_waddr, m_raddr;
   logic [EW-1:0] m_wdata;
   logic [63:0] rd_pay_ext;

   assign csr_ready  = 1'b1;
   assign req_tready = !sort_busy && !rd_pend_ff && !rsp_valid_ff;
   assign req_ok     = req_tvalid && req_tready;
   assign is_load    = req_ok && (req_tuser == CmdLoad);
   assign is_read    = req_ok && (req_tuser == CmdRead);

   assign base    = closed_ff ? '0 : fill_ff;
   assign load_we = is_load && (base < (IW+1)'(MAX_ITEMS));
   assign fill_in = load_we ? base + (IW+1)'(1) : base;
   assign pay_ext = {32'd0, req_tdata[63:32]};

   assign idx_w   = 32'(req_tdata[73:64]);
   assign fill_w  = 32'(fill_in);
   assign first_w = 32'(first_ff);
   assign last_w  = 32'(last_ff);
   assign hi_w    = (last_w > fill_w - 32'd1) ? fill_w - 32'd1 : last_w;
   assign start   = is_load && req_tlast && (fill_w != 32'd0) && (first_w <= hi_w);
   assign closed_in = is_load ? req_tlast : closed_ff;

   assign m_we    = sort_busy ? s_ctl.wr_en : load_we;
   assign m_waddr = sort_busy ? s_waddr : base[IW-1:0];
   assign m_wdata = sort_busy ? s_wdata : {req_tdata[31:0], pay_ext[PAYLOAD_WIDTH-1:0]};
   assign m_re    = sort_busy ? s_ctl.rd_en : is_read;
   assign m_raddr = sort_busy ? s_raddr : idx_w[IW-1:0];

   qks_store #(
      .ITEMS(MAX_ITEMS),
      .WIDTH(EW)
   ) u_store (
      .clock  (clock),
      .wr_en  (m_we),
      .wr_addr(m_waddr),
      .wr_data(m_wdata),
      .rd_en  (m_re),
      .rd_addr(m_raddr),
      .rd_data(rd_data)
   );

   qks_sorter #(
      .MAX_ITEMS    (MAX_ITEMS),
      .STACK_DEPTH  (STACK_DEPTH),
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
   ) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .lo         (first_w[IW-1:0]),
      .hi         (hi_w[IW-1:0]),
      .busy       (sort_busy),
      .mem_ctl    (s_ctl),
      .mem_rd_addr(s_raddr),
      .mem_wr_addr(s_waddr),
      .mem_wr_data(s_wdata),
      .mem_rd_data(rd_data)
   );

   assign rd_pay_ext = 64'(rd_data[PAYLOAD_WIDTH-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         last_ff      <= '1;
         fill_ff      <= '0;
         closed_ff    <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CsrFirstIndex) begin
            first_ff <= csr_data;
         end
         if (csr_valid && csr_index == CsrLastIndex) begin
            last_ff <= csr_data;
         end
         if (is_load) begin
            fill_ff <= fill_in;
         end
         closed_ff  <= closed_in;
         rd_pend_ff <= is_read;
         if (rd_pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_read) begin
         beyond_ff <= !(idx_w < 32'(fill_ff));
      end
      if (rd_pend_ff) begin
         rsp_user_ff <= beyond_ff;
         rsp_data_ff <= beyond_ff ? '0 : {rd_pay_ext[31:0], rd_data[EW-1 -: KeyW]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`include "assert_macros.svh"

   `QKS_ASSERT(a_fill_bound, fill_ff <= (IW+1)'(MAX_ITEMS))
   `QKS_ASSERT(a_read_not_during_sort, rd_pend_ff |-> !sort_busy)
   `QKS_ASSERT(a_beyond_zero, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
   `QKS_ASSERT(a_start_closes, start |=> closed_ff)
endmodule
`default_nettype wire

// ===== rtl/core/qks_store.sv =====
// Element memory: one write port, one read port, registered read data.
// Uses no package items.
`default_nettype none
module qks_store #(
   parameter int ITEMS = 1024,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(ITEMS)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(ITEMS)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [ITEMS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/qks_sorter.sv =====
// Quickersort sequencer: walks the element memory with at most one access per cycle.
// Depends on qks_pkg and assert_macros.svh.
`default_nettype none
module qks_sorter #(
   parameter int MAX_ITEMS     = qks_pkg::MaxItemsDefault,
   parameter int STACK_DEPTH   = qks_pkg::StackDepthDefault,
   parameter int PAYLOAD_WIDTH = qks_pkg::PayloadWidthDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [$clog2(MAX_ITEMS)-1:0]          lo,
   input  wire logic [$clog2(MAX_ITEMS)-1:0]          hi,
   output logic                                       busy,
   output qks_pkg::mem_ctl_type                       mem_ctl,
   output logic [$clog2(MAX_ITEMS)-1:0]               mem_rd_addr,
   output logic [$clog2(MAX_ITEMS)-1:0]               mem_wr_addr,
   output logic [qks_pkg::KeyW+PAYLOAD_WIDTH-1:0]     mem_wr_data,
   input  wire logic [qks_pkg::KeyW+PAYLOAD_WIDTH-1:0] mem_rd_data
);
   import qks_pkg::*;

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int SW = IW + 2;
   localparam int EW = KeyW + PAYLOAD_WIDTH;
   localparam int DW = $clog2(STACK_DEPTH + 1);

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StTop  = 4'd1;
   localparam logic [3:0] StP1   = 4'd2;
   localparam logic [3:0] StP2   = 4'd3;
   localparam logic [3:0] StK    = 4'd4;
   localparam logic [3:0] StK1   = 4'd5;
   localparam logic [3:0] StQ1   = 4'd6;
   localparam logic [3:0] StSw   = 4'd7;
   localparam logic [3:0] StFin  = 4'd8;
   localparam logic [3:0] StF1   = 4'd9;
   localparam logic [3:0] StF2   = 4'd10;
   localparam logic [3:0] StT1   = 4'd11;
   localparam logic [3:0] StT2   = 4'd12;
   localparam logic [3:0] StT3   = 4'd13;
   localparam logic [3:0] StPop  = 4'd14;

   logic [3:0] state_ff, state_in;
   logic signed [SW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, q_ff, q_in, p_ff, p_in;
   logic [EW-1:0] piv_ff, piv_in, elem_ff, elem_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic signed [SW-1:0] stk_lo_ff [STACK_DEPTH];
   logic signed [SW-1:0] stk_hi_ff [STACK_DEPTH];
   logic push;
   logic signed [SW-1:0] push_lo, push_hi;

   logic signed [SW-1:0] diff;
   logic signed [SW:0]   sum_ij;
   logic signed [SW-1:0] mid;
   logic [KeyW-1:0] ord_rd, ord_piv, ord_elem;
   logic [DW-1:0] top_idx;

   assign diff    = j_ff - i_ff;
   assign sum_ij  = {j_ff[SW-1], j_ff} + {i_ff[SW-1], i_ff};
   assign mid     = sum_ij[SW:1];
   assign ord_rd  = order_of(mem_rd_data[EW-1 -: KeyW]);
   assign ord_piv = order_of(piv_ff[EW-1 -: KeyW]);
   assign ord_elem = order_of(elem_ff[EW-1 -: KeyW]);
   assign top_idx = depth_ff - DW'(1);
   assign busy    = (state_ff != StIdle);

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      q_in        = q_ff;
      p_in        = p_ff;
      piv_in      = piv_ff;
      elem_in     = elem_ff;
      depth_in    = depth_ff;
      push        = 1'b0;
      push_lo     = i_ff;
      push_hi     = j_ff;
      mem_ctl     = '0;
      mem_rd_addr = i_ff[IW-1:0];
      mem_wr_addr = i_ff[IW-1:0];
      mem_wr_data = mem_rd_data;
      unique case (state_ff)
         StIdle: begin
            if (start) begin
               i_in     = SW'(lo);
               j_in     = SW'(hi);
               depth_in = '0;
               state_in = StTop;
            end
         end
         StTop: begin
            if (diff >= SW'(2)) begin
               p_in          = mid;
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = mid[IW-1:0];
               state_in      = StP1;
            end else if (diff == SW'(1)) begin
               mem_ctl.rd_en = 1'b1;
               state_in      = StT1;
            end else begin
               state_in = StPop;
            end
         end
         StP1: begin
            piv_in        = mem_rd_data;
            mem_ctl.rd_en = 1'b1;
            state_in      = StP2;
         end
         StP2: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = p_ff[IW-1:0];
            k_in          = i_ff + SW'(1);
            q_in          = j_ff;
            state_in      = StK;
         end
         StK: begin
            if (k_ff > q_ff) begin
               state_in = StFin;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = k_ff[IW-1:0];
               state_in      = StK1;
            end
         end
         StK1: begin
            elem_in = mem_rd_data;
            if (ord_rd <= ord_piv) begin
               k_in     = k_ff + SW'(1);
               state_in = StK;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = q_ff[IW-1:0];
               state_in      = StQ1;
            end
         end
         StQ1: begin
            priority if (!(ord_rd < ord_piv) && (q_ff - SW'(1) > k_ff)) begin
               q_in          = q_ff - SW'(1);
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = q_in[IW-1:0];
            end else if (ord_rd < ord_piv) begin
               mem_ctl.wr_en = 1'b1;
               mem_wr_addr   = k_ff[IW-1:0];
               state_in      = StSw;
            end else begin
               q_in     = k_ff - SW'(1);
               state_in = StFin;
            end
         end
         StSw: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = q_ff[IW-1:0];
            mem_wr_data   = elem_ff;
            q_in          = q_ff - SW'(1);
            k_in          = k_ff + SW'(1);
            state_in      = StK;
         end
         StFin: begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = q_ff[IW-1:0];
            state_in      = StF1;
         end
         StF1: begin
            mem_ctl.wr_en = 1'b1;
            state_in      = StF2;
         end
         StF2: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = q_ff[IW-1:0];
            mem_wr_data   = piv_ff;
            push          = (depth_ff < DW'(STACK_DEPTH));
            if ({q_ff, 1'b0} <= sum_ij) begin
               push_lo = q_ff + SW'(1);
               push_hi = j_ff;
               j_in    = q_ff - SW'(1);
            end else begin
               push_lo = i_ff;
               push_hi = q_ff - SW'(1);
               i_in    = q_ff + SW'(1);
            end
            if (push) begin
               depth_in = depth_ff + DW'(1);
            end
            state_in = StTop;
         end
         StT1: begin
            elem_in       = mem_rd_data;
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = j_ff[IW-1:0];
            state_in      = StT2;
         end
         StT2: begin
            if (ord_elem > ord_rd) begin
               mem_ctl.wr_en = 1'b1;
               state_in      = StT3;
            end else begin
               state_in = StPop;
            end
         end
         StT3: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = j_ff[IW-1:0];
            mem_wr_data   = elem_ff;
            state_in      = StPop;
         end
         StPop: begin
            if (depth_ff == '0) begin
               state_in = StIdle;
            end else begin
               depth_in = top_idx;
               i_in     = stk_lo_ff[top_idx];
               j_in     = stk_hi_ff[top_idx];
               state_in = StTop;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      q_ff    <= q_in;
      p_ff    <= p_in;
      piv_ff  <= piv_in;
      elem_ff <= elem_in;
      if (push) begin
         stk_lo_ff[depth_ff] <= push_lo;
         stk_hi_ff[depth_ff] <= push_hi;
      end
   end

`include "assert_macros.svh"

   `QKS_ASSERT(a_depth_bound, depth_ff <= DW'(STACK_DEPTH))
   `QKS_ASSERT(a_start_runs, (start && !busy) |=> busy)
   `QKS_ASSERT(a_idle_quiet, !busy |-> (!mem_ctl.rd_en && !mem_ctl.wr_en))
   `QKS_ASSERT(a_no_rw_same_cycle, !(mem_ctl.rd_en && mem_ctl.wr_en))
endmodule
`default_nettype wire
